### rtl/core/bkvt_pkg.sv
// Package: shared types and constants for the bounded key/value table.
`default_nettype none
package bkvt_pkg;
	localparam int CAPACITY   = 256;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int IDX_BITS   = $clog2(CAPACITY);
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		KIND_INSERT  = 3'd0,
		KIND_UPDATE  = 3'd1,
		KIND_UPSERT  = 3'd2,
		KIND_ERASE   = 3'd3,
		KIND_LOOKUP  = 3'd4,
		KIND_READPOS = 3'd5
	} kind_t;

	// Classified request handed from front to back.
	typedef struct packed {
		logic                  needs_search;
		logic                  is_read;
		logic                  bad_kind;
		logic [2:0]            kind;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] new_value;
		logic [7:0]            position;
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_DECIDE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_POS_RD,
		ST_POS_WAIT,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

### rtl/core/bkvt_if.sv
// Interfaces: valid/ready channels for requests and results.
`default_nettype none
interface bkvt_req_if import bkvt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [2:0]            kind;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] new_value;
	logic [7:0]            position;
	modport source (output valid, kind, key, new_value, position, input ready);
	modport sink (input valid, kind, key, new_value, position, output ready);
endinterface

interface bkvt_rsp_if import bkvt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  ok;
	logic [KEY_BITS-1:0]   found_key;
	logic [VALUE_BITS-1:0] found_value;
	logic [CNT_BITS-1:0]   entry_count;
	logic                  is_empty;
	modport source (output valid, ok, found_key, found_value, entry_count, is_empty,
		input ready);
	modport sink (input valid, ok, found_key, found_value, entry_count, is_empty,
		output ready);
endinterface
`default_nettype wire

### rtl/core/bounded_key_value_table_top.sv
// Top level: bounded key/value table with packed entries in insertion order.
//
// A request word (insert, update, insert-or-update, erase, lookup,
// read-by-position) enters a two-entry queue in the front end and is then
// carried out by the back end, which holds keys and values in two RAMs with
// registered reads. A key search reads the stored slots in order until it hits
// the key or the count; erase then compacts the later entries one slot at a
// time, reading each and writing it back one place lower. Read-by-position
// reads both RAMs at the given position. The result word is held in an output
// register while the front end accepts requests until its queue is full.
// Entry count resets to zero; data from slots past the count is never used.
`default_nettype none
module bounded_key_value_table_top import bkvt_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	bkvt_req_if.sink  req,
	bkvt_rsp_if.source rsp
);
	logic q_valid, q_pop;
	req_t q_head;

	// Accept and classify requests.
	bkvt_front u_front (.clk, .arst_n, .req, .q_valid, .q_pop, .q_head);

	// Execute against the table and drive the result word.
	bkvt_back u_back (.clk, .arst_n, .q_valid, .q_pop, .q_head, .rsp);
endmodule
`default_nettype wire

### rtl/core/bkvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module bkvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/bkvt_front.sv
// Front end: accept requests, classify them, and queue them for the back end.
`default_nettype none
module bkvt_front import bkvt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bkvt_req_if.sink   req,
	output logic       q_valid,
	input  wire logic  q_pop,
	output req_t       q_head
);
	req_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] used_q;
	req_t       cls;
	logic       push;

	always_comb begin
		cls.kind         = req.kind;
		cls.key          = req.key;
		cls.new_value    = req.new_value;
		cls.position     = req.position;
		cls.needs_search = (req.kind <= KIND_LOOKUP);
		cls.is_read      = (req.kind == KIND_READPOS);
		cls.bad_kind     = (req.kind > KIND_READPOS);
	end

	assign req.ready = (used_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (used_q != 2'd0);
	assign q_head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			used_q <= used_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

### rtl/core/bkvt_back.sv
// Back end: search, modify and compact the table, then emit one result.
`default_nettype none
module bkvt_back import bkvt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	output logic       q_pop,
	input  req_t       q_head,
	bkvt_rsp_if.source rsp
);
	state_t state_q, state_d;
	req_t   cur_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   idx_q;
	logic                  hit_q;
	logic                  ok_q;
	logic [KEY_BITS-1:0]   fk_q;
	logic [VALUE_BITS-1:0] fv_q;
	logic                  rsp_valid_q;

	logic                  k_we, v_we;
	logic [IDX_BITS-1:0]   k_waddr, v_waddr, raddr;
	logic [KEY_BITS-1:0]   k_wdata, k_rdata;
	logic [VALUE_BITS-1:0] v_wdata, v_rdata;

	bkvt_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
		.clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr, .rdata(k_rdata));
	bkvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
		.clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr, .rdata(v_rdata));

	logic [CNT_BITS-1:0] idx_inc;
	logic                full;
	logic                pos_ok;
	assign idx_inc = idx_q + 1'b1;
	assign full    = (count_q == CNT_BITS'(CAPACITY));
	assign pos_ok  = ({1'b0, cur_q.position} < count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && !rsp_valid_q) begin
					if (q_head.needs_search) state_d = ST_SRCH_RD;
					else if (q_head.is_read) state_d = ST_POS_RD;
					else state_d = ST_DONE;
				end
			end
			ST_SRCH_RD: state_d = (idx_q < count_q) ? ST_SRCH_CMP : ST_DECIDE;
			ST_SRCH_CMP: state_d = (k_rdata == cur_q.key) ? ST_DECIDE : ST_SRCH_RD;
			ST_DECIDE: begin
				if (hit_q && cur_q.kind == KIND_ERASE) state_d = ST_SHIFT_RD;
				else state_d = ST_DONE;
			end
			ST_SHIFT_RD: state_d = (idx_inc < count_q) ? ST_SHIFT_WR : ST_DONE;
			ST_SHIFT_WR: state_d = ST_SHIFT_RD;
			ST_POS_RD:   state_d = ST_POS_WAIT;
			ST_POS_WAIT: state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Memory control.
	always_comb begin
		k_we    = 1'b0;
		v_we    = 1'b0;
		k_waddr = idx_q[IDX_BITS-1:0];
		v_waddr = idx_q[IDX_BITS-1:0];
		k_wdata = cur_q.key;
		v_wdata = cur_q.new_value;
		raddr   = idx_q[IDX_BITS-1:0];
		unique case (state_q)
			ST_DECIDE: begin
				if (hit_q && (cur_q.kind == KIND_UPDATE || cur_q.kind == KIND_UPSERT)) begin
					v_we = 1'b1;
				end else if (!hit_q && !full &&
						(cur_q.kind == KIND_INSERT || cur_q.kind == KIND_UPSERT)) begin
					k_we    = 1'b1;
					v_we    = 1'b1;
					k_waddr = count_q[IDX_BITS-1:0];
					v_waddr = count_q[IDX_BITS-1:0];
				end
			end
			ST_SHIFT_RD: raddr = idx_inc[IDX_BITS-1:0];
			ST_SHIFT_WR: begin
				k_we    = 1'b1;
				v_we    = 1'b1;
				k_wdata = k_rdata;
				v_wdata = v_rdata;
			end
			ST_POS_RD: raddr = cur_q.position[IDX_BITS-1:0];
			default: ;
		endcase
	end

	assign q_pop           = (state_q == ST_IDLE) && q_valid && !rsp_valid_q;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = ok_q;
	assign rsp.found_key   = fk_q;
	assign rsp.found_value = fv_q;
	assign rsp.entry_count = count_q;
	assign rsp.is_empty    = (count_q == '0);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			ok_q        <= 1'b0;
			fk_q        <= '0;
			fv_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					// Hold the waiting result; clear only when the next word starts.
					if (q_pop) begin
						idx_q <= '0;
						hit_q <= 1'b0;
						ok_q  <= 1'b0;
						fk_q  <= '0;
						fv_q  <= '0;
					end
				end
				ST_SRCH_RD: ;
				ST_SRCH_CMP: begin
					if (k_rdata == cur_q.key) begin
						hit_q <= 1'b1;
						fv_q  <= (cur_q.kind == KIND_LOOKUP) ? v_rdata : '0;
					end else begin
						idx_q <= idx_inc;
					end
				end
				ST_DECIDE: begin
					unique case (cur_q.kind)
						KIND_INSERT: begin
							ok_q <= !hit_q && !full;
							if (!hit_q && !full) count_q <= count_q + 1'b1;
						end
						KIND_UPDATE: ok_q <= hit_q;
						KIND_UPSERT: begin
							ok_q <= hit_q || !full;
							if (!hit_q && !full) count_q <= count_q + 1'b1;
						end
						KIND_ERASE:  ok_q <= hit_q;
						KIND_LOOKUP: ok_q <= hit_q;
						default: ;
					endcase
				end
				ST_SHIFT_RD: begin
					if (!(idx_inc < count_q)) count_q <= count_q - 1'b1;
				end
				ST_SHIFT_WR: idx_q <= idx_inc;
				ST_POS_RD: ;
				ST_POS_WAIT: begin
					if (pos_ok) begin
						ok_q <= 1'b1;
						fk_q <= k_rdata;
						fv_q <= v_rdata;
					end
				end
				ST_DONE: rsp_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire
